### design/pnsg_pkg.sv
// Shared types and constants for the pulse and noise sound generator.
`timescale 1ns / 1ps
`default_nettype none

package pnsg_pkg;

  localparam int SLOT_W   = 6;
  localparam int SLOT_SPAN = 64;     // slots reachable by a write
  localparam int CNT_W    = 10;
  localparam int LEVEL_W  = 9;
  localparam int SUM_W    = 11;
  localparam int SAMPLE_W = 14;
  localparam int LFSR_W   = 15;
  localparam int NUM_PULSE = 3;
  localparam int NUM_CHAN  = 4;

  localparam logic [CNT_W-1:0]  CNT_MAX    = 10'd765;  // three times the largest period
  localparam logic [LFSR_W-1:0] LFSR_RESET = 15'h0001;

  // commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // duty codes (any other code plays as half)
  localparam logic [1:0] DUTY_QUARTER = 2'b00;
  localparam logic [1:0] DUTY_HALF    = 2'b01;
  localparam logic [1:0] DUTY_THREE_Q = 2'b10;

  localparam logic [1:0] NOISE_CHAN = 2'd3;
  localparam logic [1:0] MIX_SHIFT_RESET = 2'd2;

  typedef struct packed {
    logic [7:0] period;
    logic [1:0] duty;
    logic [7:0] volume;
  } pnsg_entry_t;

  localparam pnsg_entry_t ENTRY_RESET = '{period: 8'd0, duty: DUTY_HALF, volume: 8'd0};

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    pnsg_entry_t       entry;
  } pnsg_wr_t;

endpackage

`default_nettype wire

### design/pnsg_pattern_mem.sv
// Pattern table of one channel: memory, per-entry valid bits, registered read with bypass.
`timescale 1ns / 1ps
`default_nettype none

module pnsg_pattern_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pnsg_pkg::pnsg_wr_t    wr,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  rd_in_range,
  output pnsg_pkg::pnsg_entry_t rd_entry
);
  import pnsg_pkg::*;

  pnsg_entry_t      mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  pnsg_entry_t      rd_data_r;
  logic             rd_valid_r;
  logic             wr_en;
  logic [AW-1:0]    waddr;
  logic             wr_hit;

  assign wr_en  = wr.we && (7'(wr.slot) < 7'(DEPTH));
  assign waddr  = AW'(wr.slot);
  assign wr_hit = wr_en && (waddr == rd_addr);

  // storage and read data: no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wr.entry;
    end
    if (wr_hit) begin
      rd_data_r <= wr.entry;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[waddr] <= 1'b1;
      end
      rd_valid_r <= rd_in_range && (wr_hit || valid_r[rd_addr]);
    end
  end

  // never-written entries read as the reset entry
  assign rd_entry = rd_valid_r ? rd_data_r : ENTRY_RESET;

endmodule

`default_nettype wire

### design/pnsg_pulse_chan.sv
// Pulse channel: high/low counters with duty split, one level per tick.
`timescale 1ns / 1ps
`default_nettype none

module pnsg_pulse_chan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                tick,
  input  pnsg_pkg::pnsg_entry_t               entry,
  output logic signed [pnsg_pkg::LEVEL_W-1:0] level
);
  import pnsg_pkg::*;

  logic [CNT_W-1:0] high_count_r, high_count_nxt;
  logic [CNT_W-1:0] low_count_r, low_count_nxt;
  logic [CNT_W-1:0] per1, per2, per3, hi_len, lo_len, hi_c, lo_c;
  logic signed [LEVEL_W-1:0] vol;
  logic active;

  always_comb begin
    per1 = CNT_W'(entry.period);
    per2 = per1 << 1;
    per3 = per1 + per2;
    case (entry.duty)
      DUTY_QUARTER: begin
        hi_len = per1;
        lo_len = per3;
      end
      DUTY_THREE_Q: begin
        hi_len = per3;
        lo_len = per1;
      end
      default: begin
        hi_len = per2;
        lo_len = per2;
      end
    endcase

    // cut stale counts to the current entry, reload when both run out
    hi_c = (high_count_r > hi_len) ? hi_len : high_count_r;
    lo_c = (low_count_r > lo_len) ? lo_len : low_count_r;
    if (hi_c == '0 && lo_c == '0) begin
      hi_c = hi_len;
      lo_c = lo_len;
    end

    vol    = $signed({1'b0, entry.volume});
    active = (entry.period != '0);
    high_count_nxt = high_count_r;
    low_count_nxt  = low_count_r;
    level          = '0;
    if (active) begin
      if (hi_c != '0) begin
        high_count_nxt = hi_c - 1'b1;
        low_count_nxt  = lo_c;
        level          = vol;
      end else begin
        high_count_nxt = hi_c;
        low_count_nxt  = lo_c - 1'b1;
        level          = -vol;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_count_r <= '0;
      low_count_r  <= '0;
    end else if (tick) begin
      high_count_r <= high_count_nxt;
      low_count_r  <= low_count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (high_count_r <= CNT_MAX) && (low_count_r <= CNT_MAX))
    else $error("pulse counter above longest phase");

endmodule

`default_nettype wire

### design/pnsg_noise_chan.sv
// Noise channel: 15-bit LFSR stepped every four times the period.
`timescale 1ns / 1ps
`default_nettype none

module pnsg_noise_chan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                tick,
  input  pnsg_pkg::pnsg_entry_t               entry,
  output logic signed [pnsg_pkg::LEVEL_W-1:0] level
);
  import pnsg_pkg::*;

  logic [CNT_W-1:0]  noise_count_r, noise_count_nxt;
  logic [LFSR_W-1:0] noise_lfsr_r, noise_lfsr_nxt;
  logic              noise_negative_r, noise_negative_nxt;
  logic [CNT_W-1:0]  len, cnt_c;
  logic [LFSR_W-1:0] lfsr_step;
  logic signed [LEVEL_W-1:0] vol;

  always_comb begin
    len       = {entry.period, 2'b00};
    lfsr_step = {noise_lfsr_r[0] ^ noise_lfsr_r[1], noise_lfsr_r[LFSR_W-1:1]};
    vol       = $signed({1'b0, entry.volume});
    cnt_c     = (noise_count_r > len) ? len : noise_count_r;

    noise_count_nxt    = noise_count_r;
    noise_lfsr_nxt     = noise_lfsr_r;
    noise_negative_nxt = noise_negative_r;
    level              = '0;
    if (len != '0) begin
      if (cnt_c == '0) begin
        cnt_c              = len;
        noise_lfsr_nxt     = lfsr_step;
        noise_negative_nxt = ~lfsr_step[0];
      end
      noise_count_nxt = cnt_c - 1'b1;
      level           = noise_negative_nxt ? -vol : vol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_count_r    <= '0;
      noise_lfsr_r     <= LFSR_RESET;
      noise_negative_r <= 1'b0;
    end else if (tick) begin
      noise_count_r    <= noise_count_nxt;
      noise_lfsr_r     <= noise_lfsr_nxt;
      noise_negative_r <= noise_negative_nxt;
    end
  end

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    noise_lfsr_r != '0)
    else $error("noise LFSR locked at zero");

endmodule

`default_nettype wire

### design/pulse_noise_sound_generator.sv
// Top level of the pulse and noise sound generator.
`timescale 1ns / 1ps
`default_nettype none

// Three pulse channels and one noise channel, each playing the entry of its own
// pattern table at a shared read index. A write command loads one entry (slots at
// or beyond PATTERN_LENGTH are dropped, noise entries ignore duty), an advance
// command steps the read index with wrap, and a tick command produces one sample:
// the sum of all channel levels shifted left by the mix_shift register (cfg_wdata,
// written on cfg_we, reset 2). Only ticks give a result transfer.
// Rate: one command per cycle, sustained while out_ready is high. A tick's sample
// sits in the output register from the next cycle; while a sample waits and
// out_ready is low, in_ready is low and no command of any kind transfers. The
// single pass is set by the
// pattern tables: each is a memory with a registered read that is fetched at the
// next read index in the same cycle the index moves, with writes bypassed, so the
// current entry of every channel is always ready. Tables are cleared by per-entry
// valid bits at reset, so the block takes commands straight after reset.

module pulse_noise_sound_generator #(
  parameter int PATTERN_LENGTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [1:0]                           in_channel,
  input  logic [5:0]                           in_slot,
  input  logic [7:0]                           in_period,
  input  logic [1:0]                           in_duty,
  input  logic [7:0]                           in_volume,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pnsg_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_wdata
);
  import pnsg_pkg::*;

  // only the first SLOT_SPAN entries can ever be written
  localparam int MEM_DEPTH = (PATTERN_LENGTH < SLOT_SPAN) ? PATTERN_LENGTH : SLOT_SPAN;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int IDX_W     = (PATTERN_LENGTH > 1) ? $clog2(PATTERN_LENGTH) : 1;

  logic [IDX_W-1:0] read_index_r, read_index_nxt;
  logic [1:0]       mix_shift_r;
  logic             out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  logic accept, tick, write, advance;
  logic rd_in_range;
  logic [MEM_AW-1:0] rd_addr;
  pnsg_wr_t    wr_req [NUM_CHAN];
  pnsg_entry_t cur_entry [NUM_CHAN];
  logic signed [LEVEL_W-1:0] level [NUM_CHAN];
  logic signed [SUM_W-1:0]   sum;

  // a new sample may only enter when the output register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && (in_command == CMD_TICK);
  assign write    = accept && (in_command == CMD_WRITE);
  assign advance  = accept && (in_command == CMD_ADVANCE);

  always_comb begin
    read_index_nxt = read_index_r;
    if (advance) begin
      if (read_index_r == IDX_W'(PATTERN_LENGTH - 1)) begin
        read_index_nxt = '0;
      end else begin
        read_index_nxt = read_index_r + 1'b1;
      end
    end
    // indices past the writable slots always read the reset entry
    rd_in_range = (9'(read_index_nxt) < 9'(MEM_DEPTH));
    rd_addr     = rd_in_range ? MEM_AW'(read_index_nxt) : '0;
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      wr_req[c].we                  = write && (in_channel == 2'(c));
      wr_req[c].slot                = in_slot;
      wr_req[c].entry.period        = in_period;
      wr_req[c].entry.duty          = (2'(c) == NOISE_CHAN) ? DUTY_HALF : in_duty;
      wr_req[c].entry.volume        = in_volume;
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_tab
    pnsg_pattern_mem #(
      .DEPTH(MEM_DEPTH)
    ) u_tab (
      .clk        (clk),
      .rst_n      (rst_n),
      .wr         (wr_req[c]),
      .rd_addr    (rd_addr),
      .rd_in_range(rd_in_range),
      .rd_entry   (cur_entry[c])
    );
  end

  for (genvar c = 0; c < NUM_PULSE; c++) begin : g_pulse
    pnsg_pulse_chan u_pulse (
      .clk  (clk),
      .rst_n(rst_n),
      .tick (tick),
      .entry(cur_entry[c]),
      .level(level[c])
    );
  end

  pnsg_noise_chan u_noise (
    .clk  (clk),
    .rst_n(rst_n),
    .tick (tick),
    .entry(cur_entry[NUM_CHAN-1]),
    .level(level[NUM_CHAN-1])
  );

  // mix: four levels of +/-255 fit 11 bits; the shift fits 14
  always_comb begin
    sum = SUM_W'(level[0]) + SUM_W'(level[1]) + SUM_W'(level[2]) + SUM_W'(level[3]);
    out_sample_nxt = SAMPLE_W'(sum) <<< mix_shift_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_index_r <= '0;
      mix_shift_r  <= MIX_SHIFT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      read_index_r <= read_index_nxt;
      if (cfg_we) begin
        mix_shift_r <= cfg_wdata;
      end
      if (tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  a_tick_gives_sample: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_valid)
    else $error("tick transfer produced no sample");

  a_no_spurious_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !tick && !out_valid_r) |=> !out_valid)
    else $error("sample raised without a tick");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    read_index_r <= IDX_W'(PATTERN_LENGTH - 1))
    else $error("read index beyond pattern length");

endmodule

`default_nettype wire

### verif/pulse_noise_sound_generator_tb.sv
// Self-checking testbench for the pulse and noise sound generator.
`timescale 1ns / 1ps

module pulse_noise_sound_generator_tb;
  import pnsg_pkg::*;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;   // decoded as nothing, no sample
  localparam logic [1:0] DUTY_HALF_ALT = 2'b11;  // second encoding of half duty
  localparam int         SETTLE_CYCLES = 4;      // idle time before a register write
  localparam int         HOLD_CYCLES   = 300;    // long receiver stall

  // One command as it sits on the input ports
  typedef struct packed {
    logic [1:0] command;
    logic [1:0] channel;
    logic [5:0] slot;
    logic [7:0] period;
    logic [1:0] duty;
    logic [7:0] volume;
  } sound_cmd_t;

  // Clock, reset and every block input start at a known value
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [1:0] in_command = CMD_TICK;
  logic [1:0] in_channel = 2'd0;
  logic [5:0] in_slot = 6'd0;
  logic [7:0] in_period = 8'd0;
  logic [1:0] in_duty = DUTY_HALF;
  logic [7:0] in_volume = 8'd0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = MIX_SHIFT_RESET;
  logic in_ready;
  logic out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;

  // Stimulus plumbing
  sound_cmd_t pending_cmds[$];
  logic signed [SAMPLE_W-1:0] expected_samples[$];
  logic in_done = 1'b0;          // set by the monitor when the offered command transfers
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_left = 0;
  int errors = 0;
  logic [5:0] gen_idx = 6'd0;    // read index as the generator expects it to be

  // Predicted block state
  logic [7:0] per_tab [NUM_CHAN][SLOT_SPAN];
  logic [7:0] vol_tab [NUM_CHAN][SLOT_SPAN];
  logic [1:0] duty_tab [NUM_PULSE][SLOT_SPAN];
  logic [SLOT_W-1:0] rd_idx;
  logic [CNT_W-1:0] hi_cnt [NUM_PULSE];
  logic [CNT_W-1:0] lo_cnt [NUM_PULSE];
  logic [CNT_W-1:0] nz_cnt;
  logic [LFSR_W-1:0] lfsr;
  logic nz_neg;
  logic [1:0] mix_sh;

  pulse_noise_sound_generator #(
    .PATTERN_LENGTH(SLOT_SPAN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_command),
    .in_channel(in_channel),
    .in_slot   (in_slot),
    .in_period (in_period),
    .in_duty   (in_duty),
    .in_volume (in_volume),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sample(out_sample),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Level of one pulse channel for this tick; moves its high/low counters.
  function automatic int pulse_level(int ch);
    logic [7:0] p;
    int v;
    logic [CNT_W-1:0] hl, ll;
    p = per_tab[ch][rd_idx];
    v = int'(vol_tab[ch][rd_idx]);
    if (p == 8'd0) return 0;       // silent: counters left alone
    case (duty_tab[ch][rd_idx])
      DUTY_QUARTER: begin
        hl = CNT_W'(p);
        ll = CNT_W'(3 * p);
      end
      DUTY_THREE_Q: begin
        hl = CNT_W'(3 * p);
        ll = CNT_W'(p);
      end
      default: begin
        hl = CNT_W'(2 * p);
        ll = CNT_W'(2 * p);
      end
    endcase
    // counters left over from a longer entry are clipped to the new lengths
    if (hi_cnt[ch] > hl) hi_cnt[ch] = hl;
    if (lo_cnt[ch] > ll) lo_cnt[ch] = ll;
    if (hi_cnt[ch] == '0 && lo_cnt[ch] == '0) begin
      hi_cnt[ch] = hl;
      lo_cnt[ch] = ll;
    end
    if (hi_cnt[ch] != '0) begin
      hi_cnt[ch] = hi_cnt[ch] - 1'b1;
      return v;
    end
    lo_cnt[ch] = lo_cnt[ch] - 1'b1;
    return -v;
  endfunction

  // Noise level: sign held for 4*period ticks, then the LFSR steps.
  function automatic int noise_level();
    logic [CNT_W-1:0] len;
    logic fb;
    int v;
    len = CNT_W'(4 * per_tab[NOISE_CHAN][rd_idx]);
    v = int'(vol_tab[NOISE_CHAN][rd_idx]);
    if (len == '0) return 0;
    if (nz_cnt > len) nz_cnt = len;
    if (nz_cnt == '0) begin
      fb = lfsr[0] ^ lfsr[1];
      lfsr = {fb, lfsr[LFSR_W-1:1]};
      nz_neg = ~lfsr[0];
      nz_cnt = len;
    end
    nz_cnt = nz_cnt - 1'b1;
    return nz_neg ? -v : v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mixed_sample();
    int total;
    total = noise_level();
    for (int ch = 0; ch < NUM_PULSE; ch++) total += pulse_level(ch);
    total = total * (1 << mix_sh);
    return total[SAMPLE_W-1:0];
  endfunction

  // Applies one transferred command to the predicted state.
  function automatic void run_command(sound_cmd_t c);
    case (c.command)
      CMD_TICK: expected_samples.push_back(mixed_sample());
      CMD_WRITE: begin
        per_tab[c.channel][c.slot] = c.period;
        vol_tab[c.channel][c.slot] = c.volume;
        if (c.channel != NOISE_CHAN) duty_tab[c.channel][c.slot] = c.duty;  // noise has no duty
      end
      CMD_ADVANCE: rd_idx = rd_idx + 1'b1;   // 64 entries, so the wrap is the natural one
      default: ;                             // unused command
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample transfer with none expected, got %0d", $time, out_sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, out_sample);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_done = 1'b1;
        run_command({in_command, in_channel, in_slot, in_period, in_duty, in_volume});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers pending commands at the falling edge, with random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    sound_cmd_t nxt;
    logic offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid && !in_done;   // still waiting for its transfer
      in_done = 1'b0;
      if (!offer && pending_cmds.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = pending_cmds.pop_front();
        in_command <= nxt.command;
        in_channel <= nxt.channel;
        in_slot <= nxt.slot;
        in_period <= nxt.period;
        in_duty <= nxt.duty;
        in_volume <= nxt.volume;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // Receiver: random back-pressure, plus an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(logic [1:0] cmd, logic [1:0] ch, logic [5:0] slot,
                                    logic [7:0] per, logic [1:0] duty, logic [7:0] vol);
    pending_cmds.push_back({cmd, ch, slot, per, duty, vol});
  endfunction

  // Mostly ticks over short periods, with writes mostly aimed at the entry being played
  // or the next one, so that counters run through whole cycles.
  function automatic void queue_random_cmd();
    sound_cmd_t c;
    logic [31:0] raw;
    int pick;
    raw = $urandom;
    c = raw[$bits(sound_cmd_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 16) begin
      c.command = CMD_WRITE;
      pick = $urandom_range(99);
      if (pick < 50) c.slot = gen_idx;
      else if (pick < 75) c.slot = gen_idx + 1'b1;
      pick = $urandom_range(99);
      if (pick < 10) c.period = 8'd0;
      else if (pick < 70) c.period = 8'($urandom_range(6, 1));
      else if (pick < 90) c.period = 8'($urandom_range(40, 7));
      else c.period = 8'($urandom_range(255, 41));
    end else if (pick < 21) begin
      c.command = CMD_ADVANCE;
      gen_idx = gen_idx + 1'b1;
    end else if (pick < 23) begin
      c.command = CMD_UNUSED;
    end else begin
      c.command = CMD_TICK;
    end
    pending_cmds.push_back(c);
  endfunction

  // Sender pauses here until every expected sample has transferred and the
  // block has had time to settle.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() != 0 || in_valid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mix_shift(logic [1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    mix_sh = v;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      for (int s = 0; s < SLOT_SPAN; s++) begin
        per_tab[ch][s] = 8'd0;
        vol_tab[ch][s] = 8'd0;
        if (ch < NUM_PULSE) duty_tab[ch][s] = DUTY_HALF;
      end
    end
    for (int ch = 0; ch < NUM_PULSE; ch++) begin
      hi_cnt[ch] = '0;
      lo_cnt[ch] = '0;
    end
    rd_idx = '0;
    nz_cnt = '0;
    lfsr = LFSR_RESET;
    nz_neg = 1'b0;
    mix_sh = MIX_SHIFT_RESET;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset gain
    in_idle_pct = 0;
    out_idle_pct = 0;
    queue_cmd(CMD_TICK, 2'd0, 6'd0, 8'd0, DUTY_HALF, 8'd0);          // all silent after reset
    queue_cmd(CMD_WRITE, 2'd0, 6'd0, 8'd1, DUTY_QUARTER, 8'd255);
    queue_cmd(CMD_WRITE, 2'd1, 6'd0, 8'd255, DUTY_THREE_Q, 8'd255);
    queue_cmd(CMD_WRITE, 2'd2, 6'd0, 8'd2, DUTY_HALF_ALT, 8'd128);
    queue_cmd(CMD_WRITE, NOISE_CHAN, 6'd0, 8'd1, DUTY_HALF_ALT, 8'd255);  // duty ignored
    repeat (6) queue_cmd(CMD_TICK, 2'd0, 6'd0, 8'd0, DUTY_HALF, 8'd0);
    // shorter entry under a long-running counter: the counter gets clipped
    queue_cmd(CMD_WRITE, 2'd1, 6'd0, 8'd1, DUTY_HALF, 8'd1);
    repeat (2) queue_cmd(CMD_TICK, 2'd3, 6'd63, 8'd255, DUTY_THREE_Q, 8'd255);
    queue_cmd(CMD_WRITE, 2'd2, 6'd0, 8'd0, DUTY_QUARTER, 8'd200);        // period 0 silences
    queue_cmd(CMD_TICK, 2'd0, 6'd0, 8'd0, DUTY_HALF, 8'd0);
    queue_cmd(CMD_UNUSED, 2'd3, 6'd63, 8'd255, DUTY_HALF_ALT, 8'd255);
    queue_cmd(CMD_WRITE, 2'd0, 6'd63, 8'd255, DUTY_QUARTER, 8'd255);
    queue_cmd(CMD_WRITE, 2'd0, 6'd1, 8'd3, DUTY_HALF, 8'd7);
    queue_cmd(CMD_ADVANCE, 2'd0, 6'd0, 8'd0, DUTY_HALF, 8'd0);
    repeat (2) queue_cmd(CMD_TICK, 2'd0, 6'd0, 8'd0, DUTY_HALF, 8'd0);
    queue_cmd(CMD_ADVANCE, 2'd0, 6'd0, 8'd0, DUTY_HALF, 8'd0);
    queue_cmd(CMD_TICK, 2'd0, 6'd0, 8'd0, DUTY_HALF, 8'd0);
    gen_idx = 6'd2;
    wait_drained();

    // Random, sender idling less than the receiver, smallest gain
    set_mix_shift(2'd0);
    in_idle_pct = 27;
    out_idle_pct = 51;
    repeat (450) queue_random_cmd();
    wait_drained();

    // Random, roles swapped, largest gain; one long receiver stall fills the block
    set_mix_shift(2'd3);
    in_idle_pct = 51;
    out_idle_pct = 27;
    repeat (450) queue_random_cmd();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() > 400);
    hold_left = HOLD_CYCLES;
    wait_drained();

    // Random at full rate on both sides
    set_mix_shift(2'd1);
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (450) queue_random_cmd();
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
design/pnsg_pkg.sv
design/pnsg_pattern_mem.sv
design/pnsg_pulse_chan.sv
design/pnsg_noise_chan.sv
design/pulse_noise_sound_generator.sv
verif/pulse_noise_sound_generator_tb.sv
